// ===== src/rqts_pkg.sv =====
package rqts_pkg;

    // Task status codes, as held in the status table.
    typedef enum logic [2:0] {
        ST_UNUSED  = 3'd0,
        ST_RUNNING = 3'd1,
        ST_READY   = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_WAITING = 3'd4,
        ST_HANGING = 3'd5
    } t_status;

    // Scheduling operations; codes 5 to 7 are reserved and change nothing.
    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_PREEMPT = 3'd1,
        OP_BLOCK   = 3'd2,
        OP_UNBLOCK = 3'd3,
        OP_YIELD   = 3'd4
    } t_opcode;

    // Kinds of block requested by the block operation.
    localparam logic [1:0] KIND_BLOCKED = 2'd0;
    localparam logic [1:0] KIND_WAITING = 2'd1;
    localparam logic [1:0] KIND_HANGING = 2'd2;

    // Error codes reported with each result.
    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_IN_USE      = 2'd1;
    localparam logic [1:0] ERR_NOT_BLOCKED = 2'd2;

    // Priorities given at reset to task 0 and to the idle task.
    localparam logic [7:0] TASK0_PRIO = 8'd31;
    localparam logic [7:0] IDLE_PRIO  = 8'd10;

    // One scheduling operation.
    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] task_id;
        logic [7:0] priority_req;
        logic [1:0] block_kind;
    } t_op_item;

    // One scheduling result.
    typedef struct packed {
        logic [3:0] running_task;
        logic       switched;
        logic [7:0] slice_left;
        logic [4:0] ready_count;
        logic [1:0] error_code;
    } t_res_item;

    // True for the three statuses that a task leaves by being unblocked.
    function automatic logic is_blocked(input t_status s);
        is_blocked = (s == ST_BLOCKED) || (s == ST_WAITING) || (s == ST_HANGING);
    endfunction

endpackage

// ===== src/rqts_if.sv =====
// Channel carrying scheduling operations into the block.
interface rqts_op_if
    import rqts_pkg::*;
();
    logic     valid;
    logic     ready;
    t_op_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Channel carrying scheduling results out of the block.
interface rqts_res_if
    import rqts_pkg::*;
();
    logic      valid;
    logic      ready;
    t_res_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/rqts_ring.sv =====
module rqts_ring
    import rqts_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int IDW     = 4,
    parameter int IDLE_ID = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [IDW-1:0] i_wr_addr,
    input  logic [IDW-1:0] i_wr_data,
    input  logic [IDW-1:0] i_rd_addr,
    output logic [IDW-1:0] o_rd_data
);

    // Ready deque storage. Only the first entry has a defined reset value:
    // it holds the idle task, which is the head of the deque after reset.
    logic [IDW-1:0] r_mem [DEPTH];
    logic [IDW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem[0] <= IDW'(IDLE_ID);
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The entry that becomes the head is read ahead into a register.
    // A write to that same entry in the same cycle is passed straight through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_data <= IDW'(IDLE_ID);
        end else if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ready_queue_task_scheduler_top.sv =====
// Results are registered onto o_res. Throughput: one operation per cycle unless o_res stalls;
// the whole task table and deque update for an operation is a single pass of
// logic into the state and result registers.
// Reset (i_rst_n low, synchronous): task 0 running with priority 31, the idle
// task ready with priority 10 and alone in the deque, all other tasks unused.
module ready_queue_task_scheduler_top
    import rqts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int IDLE_TASK = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rqts_op_if.sink     i_op,
    rqts_res_if.source  o_res
);

    localparam int IDW     = $clog2(MAX_TASKS);
    localparam int CW      = $clog2(MAX_TASKS + 1);
    localparam int SW      = CW + 1;
    localparam int IDLE_ID = (IDLE_TASK != 0 && IDLE_TASK < MAX_TASKS) ? IDLE_TASK : 1;
    localparam logic [IDW-1:0] IDLE_IDX = IDW'(IDLE_ID);
    localparam logic [IDW-1:0] LAST_IDX = IDW'(MAX_TASKS - 1);

    // Task tables and deque pointers.
    t_status        r_status [MAX_TASKS];
    logic [7:0]     r_prio   [MAX_TASKS];
    logic [7:0]     r_slice  [MAX_TASKS];
    logic [IDW-1:0] r_head;
    logic [CW-1:0]  r_count;
    logic [IDW-1:0] r_cur;

    t_status        n_status [MAX_TASKS];
    logic [7:0]     n_prio   [MAX_TASKS];
    logic [7:0]     n_slice  [MAX_TASKS];
    logic [IDW-1:0] n_head;
    logic [CW-1:0]  n_count;
    logic [IDW-1:0] n_cur;

    // Result register.
    logic      r_out_valid;
    t_res_item r_res;
    t_res_item n_res;

    // Decode and deque helpers.
    t_op_item       w_op;
    logic           w_accept;
    logic           w_id_ok;
    logic [IDW-1:0] w_id;
    logic           w_not_full;
    logic [SW-1:0]  w_tail_sum;
    logic [IDW-1:0] w_tail;
    logic [IDW-1:0] w_head_dec;
    logic [IDW-1:0] w_head_inc;
    logic           w_app_cur;
    logic [CW-1:0]  w_cnt1;
    logic [IDW-1:0] w_next;
    logic           w_sw;
    logic [1:0]     w_err;
    t_status        w_block_st;

    logic           w_ring_we;
    logic [IDW-1:0] w_ring_waddr;
    logic [IDW-1:0] w_ring_wdata;
    logic [IDW-1:0] w_ring_raddr;
    logic [IDW-1:0] w_ring_rd;

    // A new operation is taken whenever the result register is free or draining.
    assign w_op       = i_op.payload;
    assign i_op.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_op.valid && i_op.ready;

    // Operand checks and ring position arithmetic.
    assign w_id_ok    = 32'(i_op.payload.task_id) < MAX_TASKS;
    assign w_id       = IDW'(w_op.task_id);
    assign w_not_full = r_count < CW'(MAX_TASKS);
    assign w_tail_sum = SW'(r_head) + SW'(r_count);
    assign w_tail     = (w_tail_sum >= SW'(MAX_TASKS)) ? IDW'(w_tail_sum - SW'(MAX_TASKS))
                                                       : IDW'(w_tail_sum);
    assign w_head_dec = (r_head == '0) ? LAST_IDX : r_head - IDW'(1);
    assign w_head_inc = (r_head == LAST_IDX) ? '0 : r_head + IDW'(1);

    // Dispatching operations put the current task back at the tail first when
    // it yields, or when it is preempted while still running.
    assign w_app_cur = (w_op.opcode == OP_YIELD)
                    || (w_op.opcode == OP_PREEMPT && r_status[r_cur] == ST_RUNNING);
    assign w_cnt1    = r_count + CW'(w_app_cur && w_not_full);

    // Status given to the current task by a block operation.
    always_comb begin
        case (w_op.block_kind)
            KIND_WAITING: w_block_st = ST_WAITING;
            KIND_HANGING: w_block_st = ST_HANGING;
            default:      w_block_st = ST_BLOCKED;
        endcase
    end

    // The ring holds the entry at the head of the next cycle ready in a register.
    assign w_ring_raddr = w_accept ? n_head : r_head;

    rqts_ring #(
        .DEPTH   (MAX_TASKS),
        .IDW     (IDW),
        .IDLE_ID (IDLE_ID)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_ring_we && w_accept),
        .i_wr_addr (w_ring_waddr),
        .i_wr_data (w_ring_wdata),
        .i_rd_addr (w_ring_raddr),
        .o_rd_data (w_ring_rd)
    );

    // Next state of the tables and the deque for the offered operation.
    always_comb begin
        n_status     = r_status;
        n_prio       = r_prio;
        n_slice      = r_slice;
        n_head       = r_head;
        n_count      = r_count;
        n_cur        = r_cur;
        w_next       = r_cur;
        w_sw         = 1'b0;
        w_err        = ERR_OK;
        w_ring_we    = 1'b0;
        w_ring_waddr = w_tail;
        w_ring_wdata = r_cur;

        unique case (w_op.opcode) inside
            OP_CREATE: begin
                if (!w_id_ok || r_status[w_id] != ST_UNUSED) begin
                    w_err = ERR_IN_USE;
                end else begin
                    n_status[w_id] = ST_READY;
                    n_prio[w_id]   = w_op.priority_req;
                    n_slice[w_id]  = w_op.priority_req;
                    if (w_not_full) begin
                        w_ring_we    = 1'b1;
                        w_ring_waddr = w_tail;
                        w_ring_wdata = w_id;
                        n_count      = r_count + CW'(1);
                    end
                end
            end
            OP_UNBLOCK: begin
                if (!w_id_ok || !is_blocked(r_status[w_id])) begin
                    w_err = ERR_NOT_BLOCKED;
                end else begin
                    n_status[w_id] = ST_READY;
                    if (w_not_full) begin
                        n_head       = w_head_dec;
                        w_ring_we    = 1'b1;
                        w_ring_waddr = w_head_dec;
                        w_ring_wdata = w_id;
                        n_count      = r_count + CW'(1);
                    end
                end
            end
            OP_PREEMPT, OP_BLOCK, OP_YIELD: begin
                w_sw = 1'b1;
                if (w_op.opcode == OP_BLOCK) begin
                    n_status[r_cur] = w_block_st;
                end
                if (w_app_cur) begin
                    n_status[r_cur] = ST_READY;
                    if (w_op.opcode == OP_PREEMPT) begin
                        n_slice[r_cur] = r_prio[r_cur];
                    end
                    if (w_not_full) begin
                        w_ring_we    = 1'b1;
                        w_ring_waddr = w_tail;
                        w_ring_wdata = r_cur;
                    end
                end
                // An empty deque dispatches the idle task straight away.
                if (w_cnt1 == '0) begin
                    w_next             = IDLE_IDX;
                    n_status[IDLE_IDX] = ST_READY;
                    n_count            = '0;
                end else begin
                    // With an empty deque the head is the entry just appended.
                    w_next  = (r_count == '0) ? r_cur : w_ring_rd;
                    n_head  = w_head_inc;
                    n_count = w_cnt1 - CW'(1);
                end
                n_status[w_next] = ST_RUNNING;
                n_cur            = w_next;
            end
            default: begin
            end
        endcase

        n_res.running_task = 4'(n_cur);
        n_res.switched     = w_sw;
        n_res.slice_left   = n_slice[n_cur];
        n_res.ready_count  = 5'(n_count);
        n_res.error_code   = w_err;
    end

    // Scheduler state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_status[i] <= ST_UNUSED;
                r_prio[i]   <= '0;
                r_slice[i]  <= '0;
            end
            r_status[0]        <= ST_RUNNING;
            r_prio[0]          <= TASK0_PRIO;
            r_slice[0]         <= TASK0_PRIO;
            r_status[IDLE_IDX] <= ST_READY;
            r_prio[IDLE_IDX]   <= IDLE_PRIO;
            r_slice[IDLE_IDX]  <= IDLE_PRIO;
            r_head             <= '0;
            r_count            <= CW'(1);
            r_cur              <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (w_accept) begin
                r_status <= n_status;
                r_prio   <= n_prio;
                r_slice  <= n_slice;
                r_head   <= n_head;
                r_count  <= n_count;
                r_cur    <= n_cur;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is loaded with each accepted operation.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;

endmodule
